@@ design/sxt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sxt_pkg
// Shared types and constants for the s-expression tokenizer: token kinds,
// character codes, token and bundle records, queue sizing.
// ----------------------------------------------------------------------------
package sxt_pkg;

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned LineBits   = 16;
  localparam int unsigned KindBits   = 3;
  localparam int unsigned MaxTokens  = 3;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  // token kinds
  localparam logic [KindBits-1:0] KindLParen = 3'd0;
  localparam logic [KindBits-1:0] KindRParen = 3'd1;
  localparam logic [KindBits-1:0] KindString = 3'd2;
  localparam logic [KindBits-1:0] KindNumber = 3'd3;
  localparam logic [KindBits-1:0] KindSymbol = 3'd4;
  localparam logic [KindBits-1:0] KindEnd    = 3'd5;
  localparam logic [KindBits-1:0] KindUnterm = 3'd6;

  // character codes
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChLBrack = 8'h5b;
  localparam logic [7:0] ChRBrack = 8'h5d;

  typedef struct packed {
    logic [KindBits-1:0]   kind;
    logic [OffsetBits-1:0] start;
    logic [OffsetBits-1:0] len;
    logic [LineBits-1:0]   line;
  } token_t;

  // all tokens caused by one input byte
  typedef struct packed {
    logic [1:0]                 cnt;
    token_t [MaxTokens-1:0]     tok;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage : sxt_pkg
`default_nettype wire

@@ design/s_expression_tokenizer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// s_expression_tokenizer_unit
// Byte-serial s-expression lexer with a queue-style input and result port.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the 4-entry bundle queue has room;
//   tokens leave one per cycle while popped, on the single result port.
// Output: a token closes when the byte that ends it is classified, as the
//   next byte (or end) is taken, and waits in the queue behind older ones.
// Reset: asynchronous, active low; idle mode, offset 0, line 1, empty queue.
module s_expression_tokenizer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [7:0]                    char_byte_i,
  input  wire logic                          is_end_i,
  input  wire logic                          pop_i,
  output logic                               empty_o,
  output logic [sxt_pkg::KindBits-1:0]       token_kind_o,
  output logic [sxt_pkg::OffsetBits-1:0]     start_offset_o,
  output logic [sxt_pkg::OffsetBits-1:0]     token_length_o,
  output logic [sxt_pkg::LineBits-1:0]       line_number_o,
  output logic                               last_of_run_o
);

  sxt_pkg::bundle_t   wr_bundle, head;
  sxt_pkg::q_status_t q_status;
  logic               wr, q_pop;

  assign full_o = q_status.full;

  sxt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .char_byte_i   (char_byte_i),
    .is_end_i      (is_end_i),
    .q_status_i    (q_status),
    .bundle_o      (wr_bundle),
    .bundle_push_o (wr)
  );

  sxt_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wr_data_i (wr_bundle),
    .rd_i      (q_pop),
    .rd_data_o (head),
    .status_o  (q_status)
  );

  sxt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_status_i     (q_status),
    .q_pop_o        (q_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .line_number_o  (line_number_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule : s_expression_tokenizer_unit
`default_nettype wire

@@ design/sxt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sxt_front
// Lexer front end: holds one byte, classifies it against the scan mode
// with the incoming byte as lookahead, and bundles the tokens it closes.
// ----------------------------------------------------------------------------
module sxt_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [7:0]          char_byte_i,
  input  wire logic                is_end_i,
  input  wire sxt_pkg::q_status_t  q_status_i,
  output sxt_pkg::bundle_t         bundle_o,
  output logic                     bundle_push_o
);

  localparam logic [2:0] ModeIdle     = 3'd0;
  localparam logic [2:0] ModeLComment = 3'd1;
  localparam logic [2:0] ModeBComment = 3'd2;
  localparam logic [2:0] ModeBClose   = 3'd3;
  localparam logic [2:0] ModeString   = 3'd4;
  localparam logic [2:0] ModeNumInt   = 3'd5;
  localparam logic [2:0] ModeNumFrac  = 3'd6;
  localparam logic [2:0] ModeSymbol   = 3'd7;

  typedef struct packed {
    logic [2:0]                     mode;
    logic [sxt_pkg::OffsetBits-1:0] pos;
    logic [sxt_pkg::OffsetBits-1:0] tb;
    logic [sxt_pkg::LineBits-1:0]   line;
  } lex_st_t;

  typedef struct packed {
    lex_st_t         st;
    logic            a_vld;
    sxt_pkg::token_t a;
    logic            b_vld;
    sxt_pkg::token_t b;
  } handle_t;

  function automatic logic is_digit(logic [7:0] ch);
    return (ch >= sxt_pkg::ChZero) && (ch <= sxt_pkg::ChNine);
  endfunction

  // classify byte c with lookahead n (n_ok low means no next byte)
  function automatic handle_t lex_handle(lex_st_t s, logic [7:0] c, logic [7:0] n,
                                         logic n_ok);
    handle_t                        r;
    logic [sxt_pkg::OffsetBits-1:0] pos_inc;
    logic [sxt_pkg::LineBits-1:0]   line_inc;
    logic                           go_idle;
    logic                           n_dig;
    logic                           blk_open;
    logic                           ws;
    r        = '0;
    r.st     = s;
    pos_inc  = (s.pos == '1) ? s.pos : s.pos + 1'b1;
    line_inc = (s.line == '1) ? s.line : s.line + 1'b1;
    n_dig    = n_ok && is_digit(n);
    blk_open = (c == sxt_pkg::ChHash) && n_ok && (n == sxt_pkg::ChLBrack);
    ws       = (c == sxt_pkg::ChSpace) || (c == sxt_pkg::ChTab) ||
               (c == sxt_pkg::ChCr) || (c == sxt_pkg::ChLf);
    go_idle  = 1'b0;
    unique case (s.mode)
      ModeIdle: go_idle = 1'b1;
      ModeLComment: begin
        if (c != sxt_pkg::ChLf) r.st.pos = pos_inc;
        else go_idle = 1'b1;
      end
      ModeBComment: begin
        if (c == sxt_pkg::ChLf) r.st.line = line_inc;
        if ((c == sxt_pkg::ChRBrack) && n_ok && (n == sxt_pkg::ChHash)) begin
          r.st.mode = ModeBClose;
        end
        r.st.pos = pos_inc;
      end
      ModeBClose: begin
        r.st.mode = ModeIdle;
        r.st.pos  = pos_inc;
      end
      ModeString: begin
        if (c == sxt_pkg::ChLf) r.st.line = line_inc;
        r.st.pos = pos_inc;
        if (c == sxt_pkg::ChQuote) begin
          r.a_vld   = 1'b1;
          r.a       = '{sxt_pkg::KindString, s.tb, pos_inc - s.tb, s.line};
          r.st.mode = ModeIdle;
        end
      end
      ModeNumInt: begin
        if (is_digit(c)) begin
          r.st.pos = pos_inc;
        end else if ((c == sxt_pkg::ChDot) && n_dig) begin
          r.st.pos  = pos_inc;
          r.st.mode = ModeNumFrac;
        end else begin
          r.a_vld = 1'b1;
          r.a     = '{sxt_pkg::KindNumber, s.tb, s.pos - s.tb, s.line};
          go_idle = 1'b1;
        end
      end
      ModeNumFrac: begin
        if (is_digit(c)) begin
          r.st.pos = pos_inc;
        end else begin
          r.a_vld = 1'b1;
          r.a     = '{sxt_pkg::KindNumber, s.tb, s.pos - s.tb, s.line};
          go_idle = 1'b1;
        end
      end
      ModeSymbol: begin
        if (!(ws || (c == sxt_pkg::ChSemi) || blk_open)) begin
          r.st.pos = pos_inc;
        end else begin
          r.a_vld = 1'b1;
          r.a     = '{sxt_pkg::KindSymbol, s.tb, s.pos - s.tb, s.line};
          go_idle = 1'b1;
        end
      end
    endcase

    if (go_idle) begin
      r.st.mode = ModeIdle;
      r.st.pos  = pos_inc;
      if (ws) begin
        if (c == sxt_pkg::ChLf) r.st.line = line_inc;
      end else if (c == sxt_pkg::ChSemi) begin
        r.st.mode = ModeLComment;
      end else if (blk_open) begin
        r.st.mode = ModeBComment;
      end else begin
        r.st.tb = s.pos;
        if ((c == sxt_pkg::ChLParen) || (c == sxt_pkg::ChRParen)) begin
          r.b_vld = 1'b1;
          r.b     = '{(c == sxt_pkg::ChLParen) ? sxt_pkg::KindLParen : sxt_pkg::KindRParen,
                      s.pos, pos_inc - s.pos, s.line};
        end else if (c == sxt_pkg::ChQuote) begin
          r.st.mode = ModeString;
        end else if (is_digit(c) || ((c == sxt_pkg::ChMinus) && n_dig)) begin
          r.st.mode = ModeNumInt;
        end else begin
          r.st.mode = ModeSymbol;
        end
      end
    end
    return r;
  endfunction

  lex_st_t    st_q, st_d, st_after;
  logic [7:0] held_q, held_d;
  logic       held_vld_q, held_vld_d;
  logic       end_in;
  logic       accept;
  handle_t    h;

  sxt_pkg::token_t [3:0] cand;
  logic [3:0]            cand_vld;
  sxt_pkg::bundle_t      bundle;

  assign end_in = is_end_i || (char_byte_i == sxt_pkg::ChNul);
  assign accept = push_i && !q_status_i.full;
  assign h      = lex_handle(st_q, held_q, char_byte_i, !end_in);
  assign st_after = held_vld_q ? h.st : st_q;

  always_comb begin
    cand_vld    = '0;
    cand[0]     = h.a;
    cand[1]     = h.b;
    cand[2]     = '{sxt_pkg::KindSymbol, st_after.tb, st_after.pos - st_after.tb,
                    st_after.line};
    cand[3]     = '{sxt_pkg::KindEnd, st_after.pos, '0, st_after.line};
    cand_vld[0] = held_vld_q && h.a_vld;
    cand_vld[1] = held_vld_q && h.b_vld;
    if (end_in) begin
      cand_vld[3] = 1'b1;
      unique case (st_after.mode)
        ModeString: begin
          cand_vld[2]  = 1'b1;
          cand[2].kind = sxt_pkg::KindUnterm;
        end
        ModeNumInt, ModeNumFrac: begin
          cand_vld[2]  = 1'b1;
          cand[2].kind = sxt_pkg::KindNumber;
        end
        ModeSymbol: cand_vld[2] = 1'b1;
        ModeIdle, ModeLComment, ModeBComment, ModeBClose: cand_vld[2] = 1'b0;
      endcase
    end
  end

  // pack valid candidates in order, keep at most three
  always_comb begin
    bundle = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_vld[i] && (bundle.cnt != 2'(sxt_pkg::MaxTokens))) begin
        bundle.tok[bundle.cnt] = cand[i];
        bundle.cnt             = bundle.cnt + 2'd1;
      end
    end
  end

  assign bundle_o      = bundle;
  assign bundle_push_o = accept && (bundle.cnt != 2'd0);

  always_comb begin
    st_d       = st_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    if (accept) begin
      if (!end_in) begin
        st_d       = st_after;
        held_d     = char_byte_i;
        held_vld_d = 1'b1;
      end else begin
        st_d       = '{ModeIdle, '0, '0, sxt_pkg::LineBits'(1)};
        held_d     = '0;
        held_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '{ModeIdle, '0, '0, sxt_pkg::LineBits'(1)};
      held_q     <= '0;
      held_vld_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
    end
  end

endmodule : sxt_front
`default_nettype wire

@@ design/sxt_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sxt_queue
// Short register queue of token bundles between the lexer front end and
// the token serializer.
// ----------------------------------------------------------------------------
module sxt_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire sxt_pkg::bundle_t  wr_data_i,
  input  wire logic              rd_i,
  output sxt_pkg::bundle_t       rd_data_o,
  output sxt_pkg::q_status_t     status_o
);

  sxt_pkg::bundle_t               mem_q [sxt_pkg::QDepth];
  logic [sxt_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [sxt_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [sxt_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                           do_wr, do_rd;

  assign status_o.full  = (cnt_q == sxt_pkg::QCntW'(sxt_pkg::QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_wr          = wr_i && !status_o.full;
  assign do_rd          = rd_i && !status_o.empty;
  assign rd_data_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    else if (!do_wr && do_rd) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule : sxt_queue
`default_nettype wire

@@ design/sxt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sxt_back
// Token serializer: walks the tokens of the oldest bundle one per pop and
// releases the bundle after its last token.
// ----------------------------------------------------------------------------
module sxt_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sxt_pkg::bundle_t                    head_i,
  input  wire sxt_pkg::q_status_t                  q_status_i,
  output logic                                     q_pop_o,
  input  wire logic                                pop_i,
  output logic                                     empty_o,
  output logic [sxt_pkg::KindBits-1:0]             token_kind_o,
  output logic [sxt_pkg::OffsetBits-1:0]           start_offset_o,
  output logic [sxt_pkg::OffsetBits-1:0]           token_length_o,
  output logic [sxt_pkg::LineBits-1:0]             line_number_o,
  output logic                                     last_of_run_o
);

  logic [1:0]      idx_q, idx_d;
  logic            last;
  sxt_pkg::token_t cur;

  assign cur            = head_i.tok[idx_q];
  assign last           = (idx_q == (head_i.cnt - 2'd1));
  assign empty_o        = q_status_i.empty;
  assign token_kind_o   = cur.kind;
  assign start_offset_o = cur.start;
  assign token_length_o = cur.len;
  assign line_number_o  = cur.line;
  assign last_of_run_o  = last;

  always_comb begin
    idx_d   = idx_q;
    q_pop_o = 1'b0;
    if (pop_i && !q_status_i.empty) begin
      if (last) begin
        q_pop_o = 1'b1;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else         idx_q <= idx_d;
  end

endmodule : sxt_back
`default_nettype wire

@@ design/sxt_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sxt_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module sxt_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          push_i,
  input wire logic                          full_o,
  input wire logic [7:0]                    char_byte_i,
  input wire logic                          is_end_i,
  input wire logic                          pop_i,
  input wire logic                          empty_o,
  input wire logic [sxt_pkg::KindBits-1:0]  token_kind_o,
  input wire logic [sxt_pkg::OffsetBits-1:0] start_offset_o,
  input wire logic [sxt_pkg::OffsetBits-1:0] token_length_o,
  input wire logic [sxt_pkg::LineBits-1:0]  line_number_o,
  input wire logic                          last_of_run_o
);

  // a waiting token holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(token_kind_o) &&
                              $stable(start_offset_o) && $stable(token_length_o)))
    else $error("waiting token changed before pop");

  // end token closes the run and has no length
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (token_kind_o == sxt_pkg::KindEnd)) |->
      (last_of_run_o && (token_length_o == '0)))
    else $error("end token malformed");

  // parens span at most one byte
  a_paren: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && ((token_kind_o == sxt_pkg::KindLParen) ||
                  (token_kind_o == sxt_pkg::KindRParen))) |-> (token_length_o <= 16'd1))
    else $error("paren token longer than one byte");

  // line count starts at one, so it is never zero; kind is in range
  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> ((line_number_o != '0) && (token_kind_o <= sxt_pkg::KindUnterm)))
    else $error("bad line number or kind");

endmodule : sxt_checker

bind s_expression_tokenizer_unit sxt_checker u_sxt_checker (.*);
`default_nettype wire
